[rtl/core/sof_pkg.sv]
package sof_pkg;

  // coordinate width and derived widths
  localparam int COORD_BITS = 16;
  localparam int DiffW      = COORD_BITS + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int NumPts     = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DiffW-1:0]      diff_t;
  typedef logic signed [ProdW-1:0]      prod_t;
  typedef logic [1:0]                   kind_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } pt_t;

  // overlap kinds
  localparam kind_t KIND_NONE    = 2'd0;
  localparam kind_t KIND_TOUCH   = 2'd1;
  localparam kind_t KIND_SEGMENT = 2'd2;

  // order by x, then by y
  function automatic logic pt_less(input pt_t a, input pt_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

[rtl/core/sof_if.sv]
interface sof_in_if import sof_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t first_start_x;
  coord_t first_start_y;
  coord_t first_end_x;
  coord_t first_end_y;
  coord_t second_start_x;
  coord_t second_start_y;
  coord_t second_end_x;
  coord_t second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface sof_out_if import sof_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_t  overlap_kind;
  coord_t lo_x;
  coord_t lo_y;
  coord_t hi_x;
  coord_t hi_y;

  modport source (
    output valid, overlap_kind, lo_x, lo_y, hi_x, hi_y,
    input  ready
  );
  modport sink (
    input  valid, overlap_kind, lo_x, lo_y, hi_x, hi_y,
    output ready
  );
endinterface

[rtl/core/segment_overlap_finder.sv]
// Overlap of two integer line segments. Each endpoint of one segment is tested
// for lying on the other (exact zero cross product plus bounding box), the
// points that pass are ordered by x then y with duplicates merged, and one
// result item comes back for every input item: no overlap (all points zero), a
// single touching point (lo equals hi) or an overlapping segment from lo to hi.
// Segments that cross away from any endpoint report no overlap. The block takes
// one item per cycle while the result side does not stall. It has five register
// stages: coordinate differences, cross products, hit flags, pairwise point
// compares and the output register. Each stage moves on whenever the one after
// it is empty or moving, so a stall on the result side backs up through the
// stages without losing any item.
module segment_overlap_finder import sof_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sof_in_if.sink    in_ch,
  sof_out_if.source out_ch
);

  // stage valid bits and load enables
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic ld1, ld2, ld3, ld4, ld5;

  assign ld5 = !out_v_r || out_ch.ready;
  assign ld4 = !s4_v_r || ld5;
  assign ld3 = !s3_v_r || ld4;
  assign ld2 = !s2_v_r || ld3;
  assign ld1 = !s1_v_r || ld2;
  assign in_ch.ready = ld1;

  // stage 1: differences and bounding box tests
  pt_t   e [NumPts];
  pt_t   s1_pt_r [NumPts];
  diff_t s1_dx_r [NumPts], s1_dy_r [NumPts], s1_px_r [NumPts], s1_py_r [NumPts];
  diff_t dx_nxt [NumPts], dy_nxt [NumPts], px_nxt [NumPts], py_nxt [NumPts];
  logic [NumPts-1:0] s1_box_r, box_nxt;

  always_comb begin
    pt_t p;
    pt_t a;
    pt_t b;
    e[0] = '{x: in_ch.first_start_x,  y: in_ch.first_start_y};
    e[1] = '{x: in_ch.first_end_x,    y: in_ch.first_end_y};
    e[2] = '{x: in_ch.second_start_x, y: in_ch.second_start_y};
    e[3] = '{x: in_ch.second_end_x,   y: in_ch.second_end_y};
    for (int t = 0; t < NumPts; t++) begin
      p = e[t];
      // first two points go against the second segment, the others the first
      a = (t < 2) ? e[2] : e[0];
      b = (t < 2) ? e[3] : e[1];
      dx_nxt[t] = diff_t'(b.x) - diff_t'(a.x);
      dy_nxt[t] = diff_t'(b.y) - diff_t'(a.y);
      px_nxt[t] = diff_t'(p.x) - diff_t'(a.x);
      py_nxt[t] = diff_t'(p.y) - diff_t'(a.y);
      box_nxt[t] = ((p.x >= a.x) || (p.x >= b.x)) && ((p.x <= a.x) || (p.x <= b.x)) &&
                   ((p.y >= a.y) || (p.y >= b.y)) && ((p.y <= a.y) || (p.y <= b.y));
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      for (int t = 0; t < NumPts; t++) begin
        s1_pt_r[t] <= e[t];
        s1_dx_r[t] <= dx_nxt[t];
        s1_dy_r[t] <= dy_nxt[t];
        s1_px_r[t] <= px_nxt[t];
        s1_py_r[t] <= py_nxt[t];
      end
      s1_box_r <= box_nxt;
    end
  end

  // stage 2: cross product halves
  pt_t   s2_pt_r [NumPts];
  prod_t s2_m1_r [NumPts], s2_m2_r [NumPts];
  logic [NumPts-1:0] s2_box_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      for (int t = 0; t < NumPts; t++) begin
        s2_pt_r[t] <= s1_pt_r[t];
        s2_m1_r[t] <= prod_t'(s1_dx_r[t]) * prod_t'(s1_py_r[t]);
        s2_m2_r[t] <= prod_t'(s1_dy_r[t]) * prod_t'(s1_px_r[t]);
      end
      s2_box_r <= s1_box_r;
    end
  end

  // stage 3: hit flags
  pt_t s3_pt_r [NumPts];
  logic [NumPts-1:0] s3_hit_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      for (int t = 0; t < NumPts; t++) begin
        s3_pt_r[t]  <= s2_pt_r[t];
        s3_hit_r[t] <= s2_box_r[t] && (s2_m1_r[t] == s2_m2_r[t]);
      end
    end
  end

  // stage 4: pairwise equal and less-than between points
  pt_t s4_pt_r [NumPts];
  logic [NumPts-1:0] s4_hit_r;
  logic [NumPts-1:0] s4_eq_r [NumPts];
  logic [NumPts-1:0] s4_lt_r [NumPts];

  always_ff @(posedge clk) begin
    if (ld4) begin
      for (int i = 0; i < NumPts; i++) begin
        s4_pt_r[i] <= s3_pt_r[i];
        for (int j = 0; j < NumPts; j++) begin
          s4_eq_r[i][j] <= (s3_pt_r[i] == s3_pt_r[j]);
          s4_lt_r[i][j] <= pt_less(s3_pt_r[i], s3_pt_r[j]);
        end
      end
      s4_hit_r <= s3_hit_r;
    end
  end

  // stage 5: merge duplicates, pick smallest and largest, output register
  logic [NumPts-1:0] first_seen, is_lo, is_hi;
  logic [2:0]        n_dist;
  pt_t               lo_pt, hi_pt;
  kind_t             kind_nxt;
  pt_t               lo_nxt, hi_nxt;
  kind_t             out_kind_r;
  pt_t               out_lo_r, out_hi_r;

  always_comb begin
    for (int i = 0; i < NumPts; i++) begin
      first_seen[i] = s4_hit_r[i];
      is_lo[i]      = s4_hit_r[i];
      is_hi[i]      = s4_hit_r[i];
      for (int j = 0; j < NumPts; j++) begin
        if (j < i && s4_hit_r[j] && s4_eq_r[j][i]) begin
          first_seen[i] = 1'b0;
        end
        if (s4_hit_r[j] && s4_lt_r[j][i]) begin
          is_lo[i] = 1'b0;
        end
        if (s4_hit_r[j] && s4_lt_r[i][j]) begin
          is_hi[i] = 1'b0;
        end
      end
    end
    n_dist = 3'($countones(first_seen));
    lo_pt = '0;
    hi_pt = '0;
    for (int i = NumPts - 1; i >= 0; i--) begin
      if (is_lo[i]) begin
        lo_pt = s4_pt_r[i];
      end
      if (is_hi[i]) begin
        hi_pt = s4_pt_r[i];
      end
    end
    case (n_dist)
      3'd1: begin
        kind_nxt = KIND_TOUCH;
        lo_nxt   = lo_pt;
        hi_nxt   = lo_pt;
      end
      3'd2: begin
        kind_nxt = KIND_SEGMENT;
        lo_nxt   = lo_pt;
        hi_nxt   = hi_pt;
      end
      default: begin
        kind_nxt = KIND_NONE;
        lo_nxt   = '0;
        hi_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      out_kind_r <= kind_nxt;
      out_lo_r   <= lo_nxt;
      out_hi_r   <= hi_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_v_r <= in_ch.valid;
      end
      if (ld2) begin
        s2_v_r <= s1_v_r;
      end
      if (ld3) begin
        s3_v_r <= s2_v_r;
      end
      if (ld4) begin
        s4_v_r <= s3_v_r;
      end
      if (ld5) begin
        out_v_r <= s4_v_r;
      end
    end
  end

  // result port
  assign out_ch.valid        = out_v_r;
  assign out_ch.overlap_kind = out_kind_r;
  assign out_ch.lo_x         = out_lo_r.x;
  assign out_ch.lo_y         = out_lo_r.y;
  assign out_ch.hi_x         = out_hi_r.x;
  assign out_ch.hi_y         = out_hi_r.y;

  // a touch reports one point twice
  a_touch_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_kind_r == KIND_TOUCH) |-> (out_lo_r == out_hi_r))
    else $error("touch result with differing points");

  // an overlapping segment runs from the smaller to the larger point
  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_kind_r == KIND_SEGMENT) |-> pt_less(out_lo_r, out_hi_r))
    else $error("segment result out of order");

  // no overlap carries zero points
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_kind_r == KIND_NONE) |-> (out_lo_r == '0) && (out_hi_r == '0))
    else $error("no-overlap result with non-zero points");

  // an accepted item is held in the first stage on the next cycle
  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_v_r)
    else $error("accepted item not captured");

endmodule

[tb/segment_overlap_finder_tb.sv]
`timescale 1ns / 1ps

module segment_overlap_finder_tb;
  import sof_pkg::*;

  // one segment pair as it crosses the input channel
  typedef struct {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  // a pair waiting to be sent; drain_first holds it back until all results are in
  typedef struct {
    seg_pair_t pair;
    bit        drain_first;
  } queued_pair_t;

  typedef struct {
    kind_t  overlap_kind;
    coord_t lo_x;
    coord_t lo_y;
    coord_t hi_x;
    coord_t hi_y;
  } overlap_t;

  logic clk;
  logic rst_n;

  sof_in_if  in_ch ();
  sof_out_if out_ch ();

  segment_overlap_finder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  queued_pair_t pending_pairs[$];
  overlap_t     expected_overlaps[$];
  seg_pair_t    pair_on_bus;
  int           error_count;
  int unsigned  cycle_count;

  // a stretch with no idling on either side
  wire idling_on = !(cycle_count >= 1500 && cycle_count < 3500);

  // exact collinearity plus bounding box
  function automatic bit lies_on_segment(longint px, longint py, longint ax, longint ay,
                                         longint bx, longint by);
    if ((bx - ax) * (py - ay) != (by - ay) * (px - ax)) return 1'b0;
    if (px < (ax < bx ? ax : bx) || px > (ax > bx ? ax : bx)) return 1'b0;
    if (py < (ay < by ? ay : by) || py > (ay > by ? ay : by)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit point_precedes(longint ax, longint ay, longint bx, longint by);
    return (ax < bx) || (ax == bx && ay < by);
  endfunction

  // expected overlap of one segment pair
  function automatic overlap_t predict_overlap(seg_pair_t p);
    longint   ex[4];
    longint   ey[4];
    longint   hx[4];
    longint   hy[4];
    longint   tx;
    longint   ty;
    int       n;
    int       i;
    int       j;
    int       k;
    int       a;
    overlap_t r;
    ex[0] = p.first_start_x;  ey[0] = p.first_start_y;
    ex[1] = p.first_end_x;    ey[1] = p.first_end_y;
    ex[2] = p.second_start_x; ey[2] = p.second_start_y;
    ex[3] = p.second_end_x;   ey[3] = p.second_end_y;
    // endpoints of each segment against the other one
    n = 0;
    for (i = 0; i < 4; i++) begin
      a = (i < 2) ? 2 : 0;
      if (lies_on_segment(ex[i], ey[i], ex[a], ey[a], ex[a+1], ey[a+1])) begin
        hx[n] = ex[i];
        hy[n] = ey[i];
        n++;
      end
    end
    // order by x then y
    for (i = 1; i < n; i++) begin
      tx = hx[i];
      ty = hy[i];
      j = i - 1;
      while (j >= 0 && point_precedes(tx, ty, hx[j], hy[j])) begin
        hx[j+1] = hx[j];
        hy[j+1] = hy[j];
        j--;
      end
      hx[j+1] = tx;
      hy[j+1] = ty;
    end
    // merge equal points
    if (n > 0) begin
      k = 1;
      for (i = 1; i < n; i++) begin
        if (hx[i] != hx[k-1] || hy[i] != hy[k-1]) begin
          hx[k] = hx[i];
          hy[k] = hy[i];
          k++;
        end
      end
      n = k;
    end
    r.overlap_kind = KIND_NONE;
    r.lo_x = '0;
    r.lo_y = '0;
    r.hi_x = '0;
    r.hi_y = '0;
    if (n == 1) begin
      r.overlap_kind = KIND_TOUCH;
      r.lo_x = coord_t'(hx[0]);
      r.lo_y = coord_t'(hy[0]);
      r.hi_x = coord_t'(hx[0]);
      r.hi_y = coord_t'(hy[0]);
    end else if (n == 2) begin
      r.overlap_kind = KIND_SEGMENT;
      r.lo_x = coord_t'(hx[0]);
      r.lo_y = coord_t'(hy[0]);
      r.hi_x = coord_t'(hx[1]);
      r.hi_y = coord_t'(hy[1]);
    end
    return r;
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, 65535));
  endfunction

  function automatic longint pick_in(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  task automatic add_pair(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
    queued_pair_t q;
    q.pair.first_start_x  = coord_t'(ax);
    q.pair.first_start_y  = coord_t'(ay);
    q.pair.first_end_x    = coord_t'(bx);
    q.pair.first_end_y    = coord_t'(by);
    q.pair.second_start_x = coord_t'(cx);
    q.pair.second_start_y = coord_t'(cy);
    q.pair.second_end_x   = coord_t'(dx);
    q.pair.second_end_y   = coord_t'(dy);
    q.drain_first = 1'b0;
    pending_pairs.push_back(q);
  endtask

  // random pair, mostly built on a common line so that overlaps and touches occur
  task automatic add_random_pair(bit drain_first);
    queued_pair_t q;
    seg_pair_t    swapped;
    longint       m;
    longint       dx;
    longint       dy;
    longint       bx;
    longint       by;
    longint       t0;
    longint       t1;
    longint       t2;
    longint       t3;
    longint       shift;
    int           shape;
    shape = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       m = 3;
      1:       m = 60;
      default: m = 4000;
    endcase
    dx = pick_in(-m, m);
    dy = pick_in(-m, m);
    bx = pick_in(-32768 + 8 * (dx < 0 ? -dx : dx), 32767 - 8 * (dx < 0 ? -dx : dx));
    by = pick_in(-32768 + 8 * (dy < 0 ? -dy : dy), 32767 - 8 * (dy < 0 ? -dy : dy));
    t0 = pick_in(-8, 8);
    t1 = pick_in(-8, 8);
    t2 = pick_in(-8, 8);
    t3 = pick_in(-8, 8);
    // noise as the starting point for every shape
    q.pair.first_start_x  = any_coord();
    q.pair.first_start_y  = any_coord();
    q.pair.first_end_x    = any_coord();
    q.pair.first_end_y    = any_coord();
    q.pair.second_start_x = any_coord();
    q.pair.second_start_y = any_coord();
    q.pair.second_end_x   = any_coord();
    q.pair.second_end_y   = any_coord();
    if (shape >= 15) begin
      q.pair.first_start_x = coord_t'(bx + t0 * dx);
      q.pair.first_start_y = coord_t'(by + t0 * dy);
      q.pair.first_end_x   = coord_t'(bx + t1 * dx);
      q.pair.first_end_y   = coord_t'(by + t1 * dy);
    end
    if (shape >= 15 && shape < 50) begin
      // collinear pair
      q.pair.second_start_x = coord_t'(bx + t2 * dx);
      q.pair.second_start_y = coord_t'(by + t2 * dy);
      q.pair.second_end_x   = coord_t'(bx + t3 * dx);
      q.pair.second_end_y   = coord_t'(by + t3 * dy);
    end else if (shape >= 50 && shape < 65) begin
      // shared endpoint, other end anywhere
      if ($urandom_range(0, 1)) begin
        q.pair.second_start_x = q.pair.first_start_x;
        q.pair.second_start_y = q.pair.first_start_y;
      end else begin
        q.pair.second_end_x = q.pair.first_end_x;
        q.pair.second_end_y = q.pair.first_end_y;
      end
    end else if (shape >= 65 && shape < 80) begin
      // one end somewhere on the first segment's line
      q.pair.second_start_x = coord_t'(bx + t2 * dx);
      q.pair.second_start_y = coord_t'(by + t2 * dy);
    end else if (shape >= 80 && shape < 90) begin
      // degenerate second segment on the line
      q.pair.second_start_x = coord_t'(bx + t2 * dx);
      q.pair.second_start_y = coord_t'(by + t2 * dy);
      q.pair.second_end_x   = q.pair.second_start_x;
      q.pair.second_end_y   = q.pair.second_start_y;
    end else if (shape >= 90) begin
      // parallel, shifted one step in x from the line
      shift = (bx > 0) ? -1 : 1;
      q.pair.second_start_x = coord_t'(bx + shift + t2 * dx);
      q.pair.second_start_y = coord_t'(by + t2 * dy);
      q.pair.second_end_x   = coord_t'(bx + shift + t3 * dx);
      q.pair.second_end_y   = coord_t'(by + t3 * dy);
    end
    // either segment may carry the built shape
    if ($urandom_range(0, 1)) begin
      swapped = q.pair;
      q.pair.first_start_x  = swapped.second_start_x;
      q.pair.first_start_y  = swapped.second_start_y;
      q.pair.first_end_x    = swapped.second_end_x;
      q.pair.first_end_y    = swapped.second_end_y;
      q.pair.second_start_x = swapped.first_start_x;
      q.pair.second_start_y = swapped.first_start_y;
      q.pair.second_end_x   = swapped.first_end_x;
      q.pair.second_end_y   = swapped.first_end_y;
    end
    q.drain_first = drain_first;
    pending_pairs.push_back(q);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_overlaps.push_back(predict_overlap(pair_on_bus));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_pairs.size() > 0 && !(idling_on && $urandom_range(0, 99) < 12) &&
            !(pending_pairs[0].drain_first && expected_overlaps.size() > 0)) begin
          pair_on_bus = pending_pairs.pop_front().pair;
          in_ch.first_start_x  <= pair_on_bus.first_start_x;
          in_ch.first_start_y  <= pair_on_bus.first_start_y;
          in_ch.first_end_x    <= pair_on_bus.first_end_x;
          in_ch.first_end_y    <= pair_on_bus.first_end_y;
          in_ch.second_start_x <= pair_on_bus.second_start_x;
          in_ch.second_start_y <= pair_on_bus.second_start_y;
          in_ch.second_end_x   <= pair_on_bus.second_end_x;
          in_ch.second_end_y   <= pair_on_bus.second_end_y;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    overlap_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_overlaps.size() == 0) begin
          $error("result item with no expectation waiting");
          error_count++;
        end else begin
          want = expected_overlaps.pop_front();
          check_field("overlap_kind", int'(want.overlap_kind), int'(out_ch.overlap_kind));
          check_field("lo_x", int'(want.lo_x), int'(out_ch.lo_x));
          check_field("lo_y", int'(want.lo_y), int'(out_ch.lo_y));
          check_field("hi_x", int'(want.hi_x), int'(out_ch.hi_x));
          check_field("hi_y", int'(want.hi_y), int'(out_ch.hi_y));
        end
      end
      out_ch.ready <= !(idling_on && $urandom_range(0, 99) < 12);
    end
  end

  // stimulus and end of run
  initial begin
    rst_n = 1'b0;
    error_count = 0;
    cycle_count = 0;
    in_ch.valid = 1'b0;
    in_ch.first_start_x  = '0;
    in_ch.first_start_y  = '0;
    in_ch.first_end_x    = '0;
    in_ch.first_end_y    = '0;
    in_ch.second_start_x = '0;
    in_ch.second_start_y = '0;
    in_ch.second_end_x   = '0;
    in_ch.second_end_y   = '0;
    out_ch.ready = 1'b0;

    // directed pairs
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    add_pair(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768);
    add_pair(-100, 0, 100, 0, 0, -100, 0, 100);
    add_pair(0, 0, 10, 0, 10, 0, 10, 10);
    add_pair(0, 0, 5, 5, 5, 5, 9, 9);
    add_pair(0, 0, 2, 2, 3, 3, 5, 5);
    add_pair(-32768, 0, 32767, 0, -5, 0, 5, 0);
    add_pair(7, -32768, 7, 100, 7, 50, 7, 32767);
    add_pair(0, 0, 10, 0, 5, 0, 5, 9);
    add_pair(3, 3, 3, 3, 0, 0, 6, 6);
    add_pair(3, 4, 3, 4, 0, 0, 6, 6);
    add_pair(1, 1, 1, 1, 2, 2, 2, 2);
    add_pair(0, 0, 10, 0, 0, 1, 10, 1);
    add_pair(32767, -32768, -32768, 32767, -1, 0, 0, -1);
    add_pair(4, 9, 4, 1, 4, 5, 4, 20);
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_pair(0, 0, 0, 5, 0, 6, 0, 9);
    add_pair(-32768, -32768, 32767, 32766, 32767, 32766, -32768, 32767);
    add_pair(-1, -1, -1, -1, -1, -1, -1, -1);
    add_pair(-32768, 32767, 32767, -32768, -32768, 32767, 0, -1);
    add_pair(5, 5, 5, 5, 5, 5, 5, 5);

    // random pairs, the sender waits for all results twice along the way
    for (int n = 0; n < 1800; n++) begin
      add_random_pair(n == 0 || n == 900);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_pairs.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_overlaps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
